[src/ndpcs_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package ndpcs_pkg;

	// Grid and priority limits.
	localparam int MAX_CELLS    = 64;
	localparam int CELL_W       = $clog2(MAX_CELLS);
	localparam int CNT_W        = CELL_W + 1;
	localparam int PRIO_W       = 4;
	localparam logic [PRIO_W-1:0] MAX_PRIORITY = PRIO_W'(9);

	// Item modes.
	localparam logic [1:0] MODE_NOTE  = 2'd0;
	localparam logic [1:0] MODE_PULSE = 2'd1;
	localparam logic [1:0] MODE_KEY   = 2'd2;
	localparam logic [1:0] MODE_PRIO  = 2'd3;

	// Key codes; codes up to KEY_DIGIT_LAST are the digit keys.
	localparam logic [3:0] KEY_DIGIT_LAST = 4'd8;
	localparam logic [3:0] KEY_LEFT       = 4'd9;
	localparam logic [3:0] KEY_UP         = 4'd10;
	localparam logic [3:0] KEY_RIGHT      = 4'd11;
	localparam logic [3:0] KEY_DOWN       = 4'd12;

	// Configuration register indexes.
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GRID_COLS  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ROOT_NOTE  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_LISTEN_CH  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_AUTO       = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_PULSE_DIR  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_ENABLED    = 3'd6;
	localparam int CFG_DATA_W = 7;

	typedef struct packed {
		logic [1:0] mode;
		logic [6:0] note_pitch;
		logic [6:0] note_velocity;
		logic [3:0] voice_index;
		logic [3:0] key_code;
		logic [3:0] priority_value;
	} item_t;

	typedef struct packed {
		logic signed [6:0] active_cell;
		logic [6:0]        note_level;
	} result_t;

	typedef struct packed {
		logic [CNT_W-1:0]  n;
		logic [3:0]        cols;
		logic [6:0]        root_note;
		logic signed [5:0] listen_channel;
		logic              auto_switch;
		logic [1:0]        pulse_direction;
		logic              enabled;
	} cfg_t;

	typedef struct packed {
		logic             trim;
		logic [CNT_W-1:0] n_new;
	} trim_t;

	typedef struct packed {
		logic load;
		logic apply;
		logic scan_init;
		logic scan_step;
		logic commit;
	} cmd_t;

	typedef struct packed {
		logic need_scan;
		logic scan_last;
	} status_t;

	function automatic logic [3:0] clamp_dim(logic [3:0] v);
		logic [3:0] r;
		if (v < 4'd1) begin
			r = 4'd1;
		end else if (v > 4'd8) begin
			r = 4'd8;
		end else begin
			r = v;
		end
		return r;
	endfunction

	function automatic logic [CNT_W-1:0] cell_count(logic [3:0] rows, logic [3:0] cols);
		logic [7:0] prod;
		prod = clamp_dim(rows) * clamp_dim(cols);
		if (prod > 8'(MAX_CELLS)) begin
			prod = 8'(MAX_CELLS);
		end
		return CNT_W'(prod);
	endfunction

endpackage

`default_nettype wire

[src/ndpcs_cfg.sv]
`timescale 1ns / 1ps
`default_nettype none

module ndpcs_cfg (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               cfg_valid,
	output      logic                               cfg_ready,
	input  wire logic [ndpcs_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [ndpcs_pkg::CFG_DATA_W-1:0]   cfg_data,
	output      ndpcs_pkg::cfg_t                    cfg,
	output      ndpcs_pkg::trim_t                   trim
);

	logic [3:0] rows_q;
	logic [3:0] cols_q;
	logic [6:0] root_q;
	logic [5:0] chan_q;
	logic       auto_q;
	logic [1:0] dir_q;
	logic       en_q;
	logic       wr;

	assign cfg_ready = 1'b1;
	assign wr        = cfg_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q <= 4'd1;
			cols_q <= 4'd1;
			root_q <= 7'd60;
			chan_q <= 6'h3f;
			auto_q <= 1'b0;
			dir_q  <= 2'd1;
			en_q   <= 1'b1;
		end else if (wr) begin
			unique case (cfg_index)
				ndpcs_pkg::REG_GRID_ROWS: rows_q <= cfg_data[3:0];
				ndpcs_pkg::REG_GRID_COLS: cols_q <= cfg_data[3:0];
				ndpcs_pkg::REG_ROOT_NOTE: root_q <= cfg_data[6:0];
				ndpcs_pkg::REG_LISTEN_CH: chan_q <= cfg_data[5:0];
				ndpcs_pkg::REG_AUTO:      auto_q <= cfg_data[0];
				ndpcs_pkg::REG_PULSE_DIR: dir_q  <= cfg_data[1:0];
				ndpcs_pkg::REG_ENABLED:   en_q   <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// A grid write trims the state to the new cell count in the same cycle.
	always_comb begin
		trim.trim  = 1'b0;
		trim.n_new = ndpcs_pkg::cell_count(rows_q, cols_q);
		if (wr && cfg_index == ndpcs_pkg::REG_GRID_ROWS) begin
			trim.trim  = 1'b1;
			trim.n_new = ndpcs_pkg::cell_count(cfg_data[3:0], cols_q);
		end else if (wr && cfg_index == ndpcs_pkg::REG_GRID_COLS) begin
			trim.trim  = 1'b1;
			trim.n_new = ndpcs_pkg::cell_count(rows_q, cfg_data[3:0]);
		end
	end

	always_comb begin
		cfg.n               = ndpcs_pkg::cell_count(rows_q, cols_q);
		cfg.cols            = ndpcs_pkg::clamp_dim(cols_q);
		cfg.root_note       = root_q;
		cfg.listen_channel  = $signed(chan_q);
		cfg.auto_switch     = auto_q;
		cfg.pulse_direction = dir_q;
		cfg.enabled         = en_q;
	end

endmodule

`default_nettype wire

[src/ndpcs_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none

module ndpcs_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output      logic               busy,
	output      logic               done,
	input  wire ndpcs_pkg::status_t status,
	output      ndpcs_pkg::cmd_t    cmd
);

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_DECODE = 3'd1;
	localparam logic [2:0] S_SCAN   = 3'd2;
	localparam logic [2:0] S_DRAIN  = 3'd3;
	localparam logic [2:0] S_COMMIT = 3'd4;
	localparam logic [2:0] S_OUT    = 3'd5;

	logic [2:0] state_q;
	logic [2:0] state_d;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = S_DECODE;
				end
			end
			S_DECODE: begin
				cmd.apply     = 1'b1;
				cmd.scan_init = 1'b1;
				state_d       = status.need_scan ? S_SCAN : S_OUT;
			end
			S_SCAN: begin
				cmd.scan_step = 1'b1;
				if (status.scan_last) begin
					state_d = S_DRAIN;
				end
			end
			S_DRAIN: begin
				state_d = S_COMMIT;
			end
			S_COMMIT: begin
				cmd.commit = 1'b1;
				state_d    = S_OUT;
			end
			S_OUT: begin
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = (state_q != S_IDLE);
	assign done = (state_q == S_OUT);

endmodule

`default_nettype wire

[src/ndpcs_dp.sv]
`timescale 1ns / 1ps
`default_nettype none

module ndpcs_dp (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire ndpcs_pkg::item_t   item,
	input  wire ndpcs_pkg::cfg_t    cfg,
	input  wire ndpcs_pkg::trim_t   trim,
	input  wire ndpcs_pkg::cmd_t    cmd,
	output      ndpcs_pkg::status_t status,
	output      ndpcs_pkg::result_t result
);

	localparam int NC  = ndpcs_pkg::MAX_CELLS;
	localparam int CW  = ndpcs_pkg::CELL_W;
	localparam int NW  = ndpcs_pkg::CNT_W;
	localparam int PW  = ndpcs_pkg::PRIO_W;

	// Reduces a in [-1, 3n) into the ring; -1 stays "no cell" unless n is one.
	function automatic logic signed [6:0] wrap_cell(logic signed [8:0] a, logic [NW-1:0] n);
		logic signed [8:0] n1;
		logic signed [8:0] n2;
		logic signed [8:0] r;
		n1 = $signed(9'(n));
		n2 = $signed(9'({n, 1'b0}));
		if (a < 0) begin
			r = (n == NW'(1)) ? 9'sd0 : -9'sd1;
		end else if (a >= n2) begin
			r = a - n2;
		end else if (a >= n1) begin
			r = a - n1;
		end else begin
			r = a;
		end
		return r[6:0];
	endfunction

	ndpcs_pkg::item_t  item_q;
	logic signed [6:0] cur_q;
	logic [6:0]        level_q;
	logic [NC-1:0]     held_q;
	logic [NC-1:0]     pvld_q;
	logic [PW-1:0]     prio_mem [NC];

	logic [CW-1:0]     idx_q;
	logic [NW-1:0]     cnt_q;
	logic              ring_q;
	logic              vld_s1;
	logic              held_s1;
	logic              pv_s1;
	logic [PW-1:0]     rd_s1;
	logic [CW-1:0]     idx_s1;
	logic              found_q;
	logic [CW-1:0]     best_q;
	logic [PW-1:0]     bestp_q;

	// Decode of the captured item.
	logic              dir_fwd;
	logic              dir_bwd;
	logic              ch_ok;
	logic signed [7:0] note_cell;
	logic              in_range;
	logic              note_ok;
	logic              pulse_ok;
	logic [CW-1:0]     cell_idx;
	logic [NC-1:0]     held_nx;
	logic signed [8:0] delta;
	logic signed [6:0] moved;
	logic [CW-1:0]     nm1;
	logic [CW-1:0]     start_idx;
	logic [CW-1:0]     ring_next;
	logic [CW-1:0]     step_src;
	logic [PW-1:0]     eff_p;
	logic [PW-1:0]     new_p;
	logic [NC-1:0]     keep;

	assign dir_fwd   = (cfg.pulse_direction == 2'd1);
	assign dir_bwd   = cfg.pulse_direction[1];
	assign ch_ok     = cfg.listen_channel[5]
	                || (6'({1'b0, item_q.voice_index} + 5'd1) == cfg.listen_channel);
	assign note_cell = $signed({1'b0, item_q.note_pitch}) - $signed({1'b0, cfg.root_note});
	assign in_range  = !note_cell[7] && (note_cell < $signed(8'(cfg.n)));
	assign cell_idx  = note_cell[CW-1:0];
	assign note_ok  = (item_q.mode == ndpcs_pkg::MODE_NOTE) && cfg.enabled && ch_ok && in_range;
	assign pulse_ok = (item_q.mode == ndpcs_pkg::MODE_PULSE) && cfg.enabled;
	assign nm1      = CW'(cfg.n - NW'(1));

	always_comb begin
		held_nx = held_q;
		if (item_q.note_velocity == 7'd0) begin
			held_nx[cell_idx] = 1'b0;
		end else if (cfg.auto_switch) begin
			held_nx[cell_idx] = 1'b1;
		end
	end

	// Ring move shared by pulses and arrow keys.
	always_comb begin
		delta = 9'sd0;
		if (item_q.mode == ndpcs_pkg::MODE_PULSE) begin
			delta = dir_bwd ? -9'sd1 : (dir_fwd ? 9'sd1 : 9'sd0);
		end else begin
			case (item_q.key_code)
				ndpcs_pkg::KEY_LEFT:  delta = -9'sd1;
				ndpcs_pkg::KEY_RIGHT: delta = 9'sd1;
				ndpcs_pkg::KEY_UP:    delta = -$signed(9'(cfg.cols));
				ndpcs_pkg::KEY_DOWN:  delta = $signed(9'(cfg.cols));
				default:              delta = 9'sd0;
			endcase
		end
	end
	assign moved = wrap_cell(9'(cur_q) + delta + $signed(9'(cfg.n)), cfg.n);

	// The pulse scan starts one step past the current cell; the note scan at cell zero.
	assign start_idx = cur_q[6] ? '0 : cur_q[CW-1:0];
	assign step_src  = cmd.scan_init ? start_idx : idx_q;
	always_comb begin
		ring_next = step_src;
		if (dir_fwd) begin
			ring_next = (step_src == nm1) ? '0 : step_src + CW'(1);
		end else if (dir_bwd) begin
			ring_next = (step_src == '0) ? nm1 : step_src - CW'(1);
		end
	end

	assign eff_p  = pv_s1 ? rd_s1 : '0;
	assign new_p  = (item_q.priority_value > ndpcs_pkg::MAX_PRIORITY)
	              ? ndpcs_pkg::MAX_PRIORITY : item_q.priority_value;

	always_comb begin
		for (int i = 0; i < NC; i++) begin
			keep[i] = (NW'(i) < trim.n_new);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			item_q <= item;
		end
	end

	// Priority store, read in the cycle after its address.
	always_ff @(posedge clk) begin
		if (cmd.apply && item_q.mode == ndpcs_pkg::MODE_PRIO && !cur_q[6]
		    && $signed(8'(cur_q)) < $signed(8'(cfg.n))) begin
			prio_mem[cur_q[CW-1:0]] <= new_p;
		end
		rd_s1 <= prio_mem[idx_q];
	end

	always_ff @(posedge clk) begin
		held_s1 <= held_q[idx_q];
		pv_s1   <= pvld_q[idx_q];
		idx_s1  <= idx_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q   <= -7'sd1;
			level_q <= '0;
			held_q  <= '0;
			pvld_q  <= '0;
			idx_q   <= '0;
			cnt_q   <= '0;
			ring_q  <= 1'b0;
			vld_s1  <= 1'b0;
			found_q <= 1'b0;
			best_q  <= '0;
			bestp_q <= '0;
		end else begin
			vld_s1 <= cmd.scan_step;
			if (trim.trim) begin
				held_q <= held_q & keep;
				pvld_q <= pvld_q & keep;
				if (!cur_q[6] && NW'(cur_q[5:0]) >= trim.n_new) begin
					cur_q <= -7'sd1;
				end
			end
			if (cmd.apply) begin
				unique case (item_q.mode)
					ndpcs_pkg::MODE_NOTE: begin
						if (note_ok) begin
							held_q <= held_nx;
							if (item_q.note_velocity != 7'd0) begin
								level_q <= item_q.note_velocity;
								if (!cfg.auto_switch) begin
									cur_q <= $signed(7'(cell_idx));
								end
							end else begin
								if (!cfg.auto_switch && cur_q == $signed(7'(cell_idx))) begin
									cur_q <= -7'sd1;
								end
								if (held_nx == '0) begin
									level_q <= '0;
								end
							end
						end
					end
					ndpcs_pkg::MODE_PULSE: begin
						if (pulse_ok && !cfg.auto_switch) begin
							cur_q <= moved;
						end
					end
					ndpcs_pkg::MODE_KEY: begin
						if (item_q.key_code <= ndpcs_pkg::KEY_DIGIT_LAST) begin
							if (NW'(item_q.key_code) < cfg.n) begin
								cur_q <= $signed(7'(item_q.key_code));
								if (cfg.auto_switch) begin
									held_q <= NC'(1) << CW'(item_q.key_code);
								end
							end
						end else if (item_q.key_code <= ndpcs_pkg::KEY_DOWN) begin
							cur_q <= moved;
						end
					end
					ndpcs_pkg::MODE_PRIO: begin
						if (!cur_q[6] && $signed(8'(cur_q)) < $signed(8'(cfg.n))) begin
							pvld_q[cur_q[CW-1:0]] <= 1'b1;
						end
					end
					default: ;
				endcase
			end
			if (cmd.scan_init) begin
				ring_q  <= (item_q.mode == ndpcs_pkg::MODE_PULSE);
				idx_q   <= (item_q.mode == ndpcs_pkg::MODE_PULSE) ? ring_next : '0;
				cnt_q   <= '0;
				found_q <= 1'b0;
			end
			if (cmd.scan_step) begin
				cnt_q <= cnt_q + NW'(1);
				idx_q <= ring_q ? ring_next : idx_q + CW'(1);
			end
			// Strict compare keeps the first cell met on a tie.
			if (vld_s1 && held_s1 && (!found_q || eff_p > bestp_q)) begin
				found_q <= 1'b1;
				best_q  <= idx_s1;
				bestp_q <= eff_p;
			end
			if (cmd.commit) begin
				if (found_q) begin
					cur_q <= $signed(7'(best_q));
				end else if (item_q.mode == ndpcs_pkg::MODE_PULSE) begin
					cur_q <= moved;
				end
			end
		end
	end

	assign status.need_scan = cfg.auto_switch && (note_ok || pulse_ok);
	assign status.scan_last = (cnt_q == cfg.n - NW'(1));

	assign result.active_cell = cur_q;
	assign result.note_level  = level_q;

endmodule

`default_nettype wire

[src/note_driven_priority_cell_selector_top.sv]
// Channel   | Handshake                      | Payload
// ----------+--------------------------------+------------------------------------
// item in   | start, busy (accept: start&!busy) | item   (ndpcs_pkg::item_t)
// result    | done, one-cycle strobe         | result (ndpcs_pkg::result_t)
// config    | cfg_valid, cfg_ready           | cfg_index (3 bits), cfg_data (7 bits)
//
// Each item yields exactly one result. An item that needs no scan goes from decode
// straight to its result strobe, and a new item is taken only once busy has dropped.
// Auto-mode note and pulse items scan the priority store one cell per cycle through
// its single read port, visiting all n cells of the grid; the drain and commit states
// follow the scan, and the result strobe comes after commit.
// Reset is asynchronous and active low and clears all held flags and priorities
// at once; no clearing pass is needed. The receiver cannot stall, so a result is
// presented for a single cycle and busy drops right after it.
`timescale 1ns / 1ps
`default_nettype none

module note_driven_priority_cell_selector_top (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                start,
	output      logic                                busy,
	input  wire ndpcs_pkg::item_t                    item,
	output      logic                                done,
	output      ndpcs_pkg::result_t                  result,
	input  wire logic                                cfg_valid,
	output      logic                                cfg_ready,
	input  wire logic [ndpcs_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [ndpcs_pkg::CFG_DATA_W-1:0]    cfg_data
);

	// Configuration registers and the cell count they imply. A write to the grid
	// size also trims held flags, priorities and the active cell to the new grid.
	ndpcs_pkg::cfg_t    cfg;
	ndpcs_pkg::trim_t   trim;
	ndpcs_pkg::cmd_t    cmd;
	ndpcs_pkg::status_t status;

	ndpcs_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg),
		.trim      (trim)
	);

	// The controller sequences capture, decode, the priority scan and the result
	// strobe; it sees the datapath only through the command and status structs.
	ndpcs_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.status (status),
		.cmd    (cmd)
	);

	// The datapath holds the selection state, the held flags and the priority
	// store, and runs the ring or linear search for the best held cell.
	ndpcs_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.cfg    (cfg),
		.trim   (trim),
		.cmd    (cmd),
		.status (status),
		.result (result)
	);

endmodule

`default_nettype wire
